### hdl/mpr_pkg.sv
// Shared widths, types and operation codes for the midpoint parabola rasterizer.
package mpr_pkg;

    localparam int COORD_W  = 11;
    localparam int FOCAL_W  = 10;
    localparam int MAJOR_W  = 12;
    localparam int MINOR_W  = 13;
    localparam int DEC_W    = 28;
    localparam int PIXEL_W  = 14;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    typedef logic signed [DEC_W-1:0]   dec_t;
    typedef logic signed [PIXEL_W-1:0] pixel_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

endpackage

### hdl/midpoint_parabola_rasterizer_core.sv
// Midpoint parabola rasterizer: start loads a curve, each step of an active curve emits one mirrored pixel pair.
//
//  channel | dir | tdata (low bit up)                               | tuser / tlast
//  s_      | in  | vertex_x[10:0] vertex_y[21:11] focal_length[31:22]| tuser = operation
//          |     | vertical_axis[32], zero fill to 40                |
//  m_      | out | first_x[13:0] first_y[27:14] second_x[41:28]      | tlast = last_point
//          |     | second_y[55:42]                                   |
//
// One input transfer per cycle while s_tready is high; a step's pair appears in the output register
// in the cycle after its transfer, built from the offsets held before that step's update.
// The region switch uses a running 16*a*major term and a constant fixed at start.
// Reset clears the curve and output valid. s_tready drops only while a result is held
// and m_tready is low; starts and idle steps also wait then.
module midpoint_parabola_rasterizer_core
    import mpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // vertex_x, vertex_y, focal_length, vertical_axis
    input  logic                s_tuser,   // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // first_x, first_y, second_x, second_y
    output logic                m_tlast
);

    logic                curve_active_reg, curve_active_next;
    logic                in_second_region_reg, in_second_region_next;
    logic                axis_vertical_reg, axis_vertical_next;
    logic [COORD_W-1:0]  origin_col_reg, origin_col_next;
    logic [COORD_W-1:0]  origin_row_reg, origin_row_next;
    logic [FOCAL_W-1:0]  focal_held_reg, focal_held_next;
    logic [MAJOR_W-1:0]  major_offset_reg, major_offset_next;
    logic [MINOR_W-1:0]  minor_offset_reg, minor_offset_next;
    dec_t                decision_reg, decision_next;
    dec_t                scaled_major_reg, scaled_major_next;  // 16 * a * major
    dec_t                entry_const_reg, entry_const_next;    // 16a^2 + 8a + 9

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic                accept;
    logic [COORD_W-1:0]  in_col, in_row;
    logic [FOCAL_W-1:0]  in_focal;
    logic [2*FOCAL_W-1:0] focal_sq;
    dec_t                in_a;
    dec_t                a_ext, min_ext, r1_sum, r2_sum;
    logic [MINOR_W-1:0]  min_r1;
    logic [MAJOR_W-1:0]  maj_r1;
    dec_t                scaled_r1;
    logic                enter_r2;
    pixel_t              col_p, row_p, maj_p, min_p;
    pixel_t              fx, fy, sx, sy;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign in_col   = s_tdata[10:0];
    assign in_row   = s_tdata[21:11];
    assign in_focal = s_tdata[31:22];
    assign focal_sq = in_focal * in_focal;
    assign in_a     = dec_t'({{(DEC_W-FOCAL_W){1'b0}}, in_focal});

    assign a_ext   = dec_t'({{(DEC_W-FOCAL_W){1'b0}}, focal_held_reg});
    assign min_ext = dec_t'({{(DEC_W-MINOR_W){1'b0}}, minor_offset_reg});

    // region 1 pieces
    assign r1_sum    = decision_reg + dec_t'(3) + (min_ext <<< 1);
    assign min_r1    = minor_offset_reg + MINOR_W'(1);
    assign maj_r1    = major_offset_reg + MAJOR_W'(decision_reg >= 0);
    assign scaled_r1 = (decision_reg >= 0) ? scaled_major_reg + (a_ext <<< 4)
                                           : scaled_major_reg;
    assign enter_r2  = min_r1 > {2'b00, focal_held_reg, 1'b0};
    // region 2 step when the minor offset advances
    assign r2_sum    = decision_reg + dec_t'(8) + (min_ext <<< 3) - (a_ext <<< 4);

    // pixel pair from the pre-update offsets, wrapped to 14 bits
    assign col_p = pixel_t'({3'b000, origin_col_reg});
    assign row_p = pixel_t'({3'b000, origin_row_reg});
    assign maj_p = pixel_t'({2'b00, major_offset_reg});
    assign min_p = pixel_t'({1'b0, minor_offset_reg});

    always_comb begin
        if (axis_vertical_reg) begin
            fx = col_p + min_p;
            fy = row_p + maj_p;
            sx = col_p - min_p;
            sy = row_p + maj_p;
        end else begin
            fx = col_p + maj_p;
            fy = row_p + min_p;
            sx = col_p + maj_p;
            sy = row_p - min_p;
        end
    end

    always_comb begin
        curve_active_next     = curve_active_reg;
        in_second_region_next = in_second_region_reg;
        axis_vertical_next    = axis_vertical_reg;
        origin_col_next       = origin_col_reg;
        origin_row_next       = origin_row_reg;
        focal_held_next       = focal_held_reg;
        major_offset_next     = major_offset_reg;
        minor_offset_next     = minor_offset_reg;
        decision_next         = decision_reg;
        scaled_major_next     = scaled_major_reg;
        entry_const_next      = entry_const_reg;
        m_valid_next          = m_valid_reg && !m_tready;
        m_data_next           = m_data_reg;
        m_last_next           = m_last_reg;

        if (accept) begin
            case (op_t'(s_tuser))
                OP_START: begin
                    origin_col_next       = in_col;
                    origin_row_next       = in_row;
                    focal_held_next       = in_focal;
                    axis_vertical_next    = s_tdata[32];
                    major_offset_next     = '0;
                    minor_offset_next     = '0;
                    in_second_region_next = 1'b0;
                    decision_next         = dec_t'(1) - (in_a <<< 1);
                    scaled_major_next     = '0;
                    entry_const_next      = dec_t'({4'b0000, focal_sq, 4'b0000})
                                            + (in_a <<< 3) + dec_t'(9);
                    curve_active_next     = 1'b1;
                end
                OP_STEP: begin
                    if (curve_active_reg) begin
                        if (!in_second_region_reg) begin
                            minor_offset_next = min_r1;
                            major_offset_next = maj_r1;
                            scaled_major_next = scaled_r1;
                            if (enter_r2) begin
                                in_second_region_next = 1'b1;
                                // exact scaled midpoint value at the switch point
                                decision_next = entry_const_reg - scaled_r1;
                            end else if (decision_reg < 0) begin
                                decision_next = r1_sum;
                            end else begin
                                decision_next = r1_sum - (a_ext <<< 2);
                            end
                        end else begin
                            if (decision_reg > 0) begin
                                decision_next = decision_reg - (a_ext <<< 4);
                            end else begin
                                decision_next     = r2_sum;
                                minor_offset_next = min_r1;
                            end
                            major_offset_next = major_offset_reg + MAJOR_W'(1);
                        end
                        m_last_next = in_second_region_next &&
                                      (major_offset_next > {1'b0, focal_held_reg, 1'b0});
                        if (m_last_next) begin
                            curve_active_next = 1'b0;
                        end
                        m_valid_next = 1'b1;
                        m_data_next  = {sy, sx, fy, fx};
                    end
                end
                default: begin
                    curve_active_next = curve_active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_active_reg     <= 1'b0;
            in_second_region_reg <= 1'b0;
            axis_vertical_reg    <= 1'b0;
            origin_col_reg       <= '0;
            origin_row_reg       <= '0;
            focal_held_reg       <= '0;
            major_offset_reg     <= '0;
            minor_offset_reg     <= '0;
            decision_reg         <= '0;
            scaled_major_reg     <= '0;
            entry_const_reg      <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            curve_active_reg     <= curve_active_next;
            in_second_region_reg <= in_second_region_next;
            axis_vertical_reg    <= axis_vertical_next;
            origin_col_reg       <= origin_col_next;
            origin_row_reg       <= origin_row_next;
            focal_held_reg       <= focal_held_next;
            major_offset_reg     <= major_offset_next;
            minor_offset_reg     <= minor_offset_next;
            decision_reg         <= decision_next;
            scaled_major_reg     <= scaled_major_next;
            entry_const_reg      <= entry_const_next;
            m_valid_reg          <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule
